[sv/ptbl_pkg.sv]
// Shared types and constants of the per-user token bucket limiter.
package ptbl_pkg;

	localparam int USER_SLOTS = 1024;
	localparam int SLOT_BITS = $clog2(USER_SLOTS);
	localparam int TIME_BITS = 32;
	localparam int TOKEN_BITS = 16;
	localparam int DIV_BITS = TIME_BITS;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_AMOUNT = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	localparam logic [TOKEN_BITS-1:0] RST_CAPACITY = 16'd300;
	localparam logic [TOKEN_BITS-1:0] RST_AMOUNT = 16'd100;
	localparam logic [31:0] RST_PERIOD = 32'd600;

	typedef struct packed {
		logic [TOKEN_BITS-1:0] capacity;
		logic [TOKEN_BITS-1:0] amount;
		logic [31:0]           period;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [TOKEN_BITS-1:0] tokens;
		logic [TIME_BITS-1:0]  last;
	} entry_t;

	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_addr;
		entry_t               wr_data;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_CLAMP,
		ST_FINAL
	} state_t;

endpackage

[sv/ptbl_if.sv]
// Request and response channel interfaces of the token bucket limiter.
interface ptbl_req_if;
	logic        valid;
	logic        ready;
	logic [9:0]  user_slot;
	logic [31:0] current_time;
	logic [15:0] request_cost;

	modport source (output valid, user_slot, current_time, request_cost, input ready);
	modport sink (input valid, user_slot, current_time, request_cost, output ready);
endinterface

interface ptbl_rsp_if;
	logic        valid;
	logic        ready;
	logic        rejected;
	logic [15:0] tokens_left;
	logic        slot_was_new;

	modport source (output valid, rejected, tokens_left, slot_was_new, input ready);
	modport sink (input valid, rejected, tokens_left, slot_was_new, output ready);
endinterface

[sv/ptbl_div.sv]
// Restoring divider, one quotient bit per cycle.
module ptbl_div
	import ptbl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DIV_BITS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_BITS - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DIV_BITS-1:0] dsr_q;
	logic [DIV_BITS:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_BITS'(trial - {1'b0, dsr_q}) : trial[DIV_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

[sv/ptbl_store.sv]
// Slot table memory with its clearing sweep after reset.
module ptbl_store
	import ptbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output entry_t     rd_data,
	output logic       ready
);

	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(USER_SLOTS - 1);

	entry_t               mem [USER_SLOTS];
	entry_t               rd_q;
	logic                 clr_q;
	logic [SLOT_BITS-1:0] clr_addr_q;
	logic                 we;
	logic [SLOT_BITS-1:0] wa;
	entry_t               wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_SLOT) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = clr_q | req.wr_en;
		wa = clr_q ? clr_addr_q : req.wr_addr;
		wd = clr_q ? '0 : req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready = !clr_q;

endmodule

[sv/ptbl_cfg.sv]
// APB configuration registers of the token bucket limiter.
module ptbl_cfg
	import ptbl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign idx = paddr[3:2];
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= RST_CAPACITY;
			cfg_q.amount <= RST_AMOUNT;
			cfg_q.period <= RST_PERIOD;
		end else if (wr) begin
			case (idx)
				REG_CAPACITY: cfg_q.capacity <= pwdata[TOKEN_BITS-1:0];
				REG_AMOUNT:   cfg_q.amount <= pwdata[TOKEN_BITS-1:0];
				REG_PERIOD:   cfg_q.period <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CAPACITY: prdata = APB_DATA_BITS'(cfg_q.capacity);
			REG_AMOUNT:   prdata = APB_DATA_BITS'(cfg_q.amount);
			REG_PERIOD:   prdata = cfg_q.period;
			default:      prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg = cfg_q;

endmodule

[sv/ptbl_ctrl.sv]
// Read-modify-write sequencer: refill, clamp, admission and write back.
module ptbl_ctrl
	import ptbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ptbl_req_if.sink   req,
	ptbl_rsp_if.source rsp,
	input  cfg_t       cfg,
	input  logic       store_ready,
	input  entry_t     rd_data,
	output store_req_t mem_req
);

	state_t                state_q;
	state_t                state_d;

	logic [SLOT_BITS-1:0]  slot_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TOKEN_BITS-1:0] cost_q;
	logic                  new_q;
	logic [TOKEN_BITS-1:0] tokens_q;
	logic [TIME_BITS-1:0]  last_q;
	logic [TOKEN_BITS-1:0] n_q;
	logic [31:0]           addt_q;
	logic [TIME_BITS-1:0]  addl_q;

	logic                  rsp_valid_q;
	logic                  rejected_q;
	logic [TOKEN_BITS-1:0] left_q;
	logic                  was_new_q;

	logic                  accept;
	logic                  refill;
	logic                  div_start;
	logic                  div_done;
	logic                  e_done;
	logic                  k_done;
	logic [DIV_BITS-1:0]   e_quo;
	logic [DIV_BITS-1:0]   k_quo;
	logic [DIV_BITS-1:0]   e_dvd;
	logic [DIV_BITS-1:0]   k_dvd;
	logic [31:0]           period_eff;
	logic [TOKEN_BITS:0]   need;
	logic [TOKEN_BITS-1:0] n_d;
	logic [31:0]           prod_t;
	logic [47:0]           prod_l;
	logic [32:0]           sum_t;
	logic                  out_free;
	logic                  rej;
	logic                  finish;

	assign period_eff = (cfg.period == '0) ? 32'd1 : cfg.period;
	assign refill = (rd_data.tokens < cfg.capacity) && (cfg.amount != '0)
		&& (now_q > rd_data.last);
	assign e_dvd = DIV_BITS'(now_q - rd_data.last - 1'b1);
	assign k_dvd = DIV_BITS'(cfg.capacity - rd_data.tokens - 1'b1);

	ptbl_div u_div_elapsed (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (e_dvd),
		.divisor  (DIV_BITS'(period_eff)),
		.done     (e_done),
		.quotient (e_quo)
	);

	ptbl_div u_div_need (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (k_dvd),
		.divisor  (DIV_BITS'(cfg.amount)),
		.done     (k_done),
		.quotient (k_quo)
	);

	assign div_done = e_done & k_done;
	assign need = {1'b0, k_quo[TOKEN_BITS-1:0]} + 1'b1;
	assign n_d = (e_quo < DIV_BITS'(need)) ? e_quo[TOKEN_BITS-1:0] : need[TOKEN_BITS-1:0];
	assign prod_t = {16'b0, n_q} * {16'b0, cfg.amount};
	assign prod_l = {32'b0, n_q} * {16'b0, period_eff};
	assign sum_t = {17'b0, tokens_q} + {1'b0, addt_q};
	assign out_free = !rsp_valid_q || rsp.ready;
	assign rej = cost_q > tokens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept = 1'b0;
		div_start = 1'b0;
		finish = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = store_ready;
				accept = store_ready && req.valid;
				if (accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!rd_data.valid) begin
					state_d = ST_FINAL;
				end else if (refill) begin
					div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_CLAMP;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_ADD;
			ST_ADD:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_FINAL;
			ST_FINAL: begin
				if (out_free) begin
					finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req.rd_en = accept;
		mem_req.rd_addr = req.user_slot[SLOT_BITS-1:0];
		mem_req.wr_en = finish && !rej;
		mem_req.wr_addr = slot_q;
		mem_req.wr_data.valid = 1'b1;
		mem_req.wr_data.tokens = tokens_q - cost_q;
		mem_req.wr_data.last = last_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					slot_q <= req.user_slot[SLOT_BITS-1:0];
					now_q <= req.current_time[TIME_BITS-1:0];
					cost_q <= req.request_cost;
				end
			end
			ST_LOAD: begin
				new_q <= !rd_data.valid;
				if (!rd_data.valid) begin
					tokens_q <= cfg.capacity;
					last_q <= now_q;
				end else begin
					tokens_q <= rd_data.tokens;
					last_q <= rd_data.last;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					n_q <= n_d;
				end
			end
			ST_MUL: begin
				addt_q <= prod_t;
				addl_q <= prod_l[TIME_BITS-1:0];
			end
			ST_ADD: begin
				tokens_q <= (sum_t > {17'b0, cfg.capacity}) ? cfg.capacity
					: sum_t[TOKEN_BITS-1:0];
				last_q <= last_q + addl_q;
			end
			ST_CLAMP: begin
				if (tokens_q >= cfg.capacity) begin
					tokens_q <= cfg.capacity;
					last_q <= now_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rejected_q <= rej;
			left_q <= rej ? tokens_q : tokens_q - cost_q;
			was_new_q <= new_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.rejected = rejected_q;
	assign rsp.tokens_left = left_q;
	assign rsp.slot_was_new = was_new_q;

endmodule

[sv/per_user_token_bucket_limiter.sv]
// Top level of the per-user token bucket limiter.
//
//  port     dir   kind                    carries
//  req      in    valid/ready word        user_slot, current_time, request_cost
//  rsp      out   valid/ready word        rejected, tokens_left, slot_was_new
//  apb      in    APB, 4-bit byte addr    bucket_capacity, refill_amount, refill_period
//
// Before rsp.valid rises, a new slot passes LOAD and FINAL, a known slot with no refill
// LOAD, CLAMP and FINAL, and a refill also DIV, MUL and ADD, where two 32-step restoring
// dividers count elapsed periods and needed refills in parallel. One request is in
// flight at a time; the next is accepted the cycle after its result is loaded into the
// rsp register. After reset a clearing sweep invalidates every slot; req.ready stays
// low until it ends. A result held on rsp holds the next one in its final state.
module per_user_token_bucket_limiter
	import ptbl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	ptbl_req_if.sink                 req,
	ptbl_rsp_if.source               rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t       cfg;
	store_req_t mem_req;
	entry_t     rd_data;
	logic       store_ready;

	ptbl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptbl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data),
		.ready   (store_ready)
	);

	ptbl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.store_ready (store_ready),
		.rd_data     (rd_data),
		.mem_req     (mem_req)
	);

endmodule

[test/ptbl_admission_check.sv]
// Checker for the token bucket limiter: predicts each request's verdict and compares results.
module ptbl_admission_check
	import ptbl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	ptbl_req_if                      req,
	ptbl_rsp_if                      rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output int                       mismatch_count,
	output int                       owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                  rejected;
		logic [TOKEN_BITS-1:0] tokens_left;
		logic                  slot_was_new;
	} verdict_t;

	verdict_t pending_verdicts[$];

	logic [TOKEN_BITS-1:0] lim_cap;
	logic [TOKEN_BITS-1:0] lim_amt;
	logic [31:0]           lim_per;

	bit                    tbl_valid[USER_SLOTS];
	bit [TOKEN_BITS-1:0]   tbl_tokens[USER_SLOTS];
	bit [TIME_BITS-1:0]    tbl_last[USER_SLOTS];

	function automatic verdict_t admit_request(logic [SLOT_BITS-1:0] slot,
			logic [TIME_BITS-1:0] now, logic [TOKEN_BITS-1:0] cost);
		bit [63:0] cap;
		bit [63:0] tokens;
		bit [63:0] last;
		bit [63:0] period;
		bit [63:0] elapsed;
		bit [63:0] need;
		bit [63:0] steps;
		bit        fresh;
		verdict_t  v;
		cap = 64'(lim_cap);
		tokens = cap;
		last = 64'(now);
		fresh = !tbl_valid[slot];
		if (!fresh) begin
			period = (lim_per == 0) ? 64'd1 : 64'(lim_per);
			tokens = 64'(tbl_tokens[slot]);
			last = 64'(tbl_last[slot]);
			if (tokens < cap && lim_amt != 0 && 64'(now) > last) begin
				elapsed = (64'(now) - last - 64'd1) / period;
				need = (cap - tokens + 64'(lim_amt) - 64'd1) / 64'(lim_amt);
				steps = (elapsed < need) ? elapsed : need;
				tokens = tokens + steps * 64'(lim_amt);
				last = last + steps * period;
			end
			if (tokens > cap)
				tokens = cap;
			if (tokens == cap)
				last = 64'(now);
		end
		v.slot_was_new = fresh;
		if (64'(cost) > tokens) begin
			v.rejected = 1'b1;
		end else begin
			tokens = tokens - 64'(cost);
			tbl_tokens[slot] = tokens[TOKEN_BITS-1:0];
			tbl_last[slot] = last[TIME_BITS-1:0];
			tbl_valid[slot] = 1'b1;
			v.rejected = 1'b0;
		end
		v.tokens_left = tokens[TOKEN_BITS-1:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			lim_cap = RST_CAPACITY;
			lim_amt = RST_AMOUNT;
			lim_per = RST_PERIOD;
			foreach (tbl_valid[i])
				tbl_valid[i] = 1'b0;
			pending_verdicts.delete();
			mismatch_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_BITS-1:2])
					REG_CAPACITY: lim_cap = pwdata[TOKEN_BITS-1:0];
					REG_AMOUNT:   lim_amt = pwdata[TOKEN_BITS-1:0];
					REG_PERIOD:   lim_per = pwdata[31:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("result word with no request outstanding");
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp.rejected !== want.rejected) begin
						$error("rejected: expected %0d, got %0d", want.rejected, rsp.rejected);
						mismatch_count++;
					end
					if (rsp.tokens_left !== want.tokens_left) begin
						$error("tokens_left: expected %0d, got %0d", want.tokens_left,
							rsp.tokens_left);
						mismatch_count++;
					end
					if (rsp.slot_was_new !== want.slot_was_new) begin
						$error("slot_was_new: expected %0d, got %0d", want.slot_was_new,
							rsp.slot_was_new);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready)
				pending_verdicts.push_back(admit_request(req.user_slot, req.current_time,
					req.request_cost));
		end
		owed = pending_verdicts.size();
	end

endmodule

[test/tb.sv]
// Testbench top: drives requests and register writes into the limiter and reports the verdict.
module tb
	import ptbl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int POOL_SIZE = 12;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 153;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_PULSE
	} stall_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     req_taken = 1'b0;
	int                       fails;
	int                       owed;

	int unsigned              burst_left = 0;
	logic [SLOT_BITS-1:0]     slot_pool[POOL_SIZE];
	logic [TIME_BITS-1:0]     wall;
	logic [TOKEN_BITS-1:0]    cur_cap = RST_CAPACITY;
	logic [31:0]              cur_per = RST_PERIOD;

	ptbl_req_if req();
	ptbl_rsp_if rsp();

	per_user_token_bucket_limiter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ptbl_admission_check admission_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (fails),
		.owed           (owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		req_taken <= req.valid && req.ready;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("per_user_token_bucket_limiter regression: fail");
		$finish;
	end

	initial begin
		stall_mode_t mode;
		int unsigned left;
		mode = STALL_NONE;
		left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(8, 120);
			end
			left--;
			case (mode)
				STALL_NONE:  rsp.ready <= 1'b1;
				STALL_COIN:  rsp.ready <= ($urandom_range(0, 1) == 1);
				STALL_HEAVY: rsp.ready <= ($urandom_range(0, 5) == 0);
				default:     rsp.ready <= (left % 4 != 0);
			endcase
		end
	end

	task automatic send_word(logic [SLOT_BITS-1:0] slot, logic [TIME_BITS-1:0] now,
			logic [TOKEN_BITS-1:0] cost);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.user_slot <= slot;
		req.current_time <= now;
		req.request_cost <= cost;
		do @(negedge clk); while (!req_taken);
	endtask

	// hold the sender until every verdict has come back
	task automatic settle();
		req.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (owed != 0) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'({index, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
	endtask

	task automatic set_limits(logic [15:0] cap, logic [15:0] amt, logic [31:0] per);
		reg_write(REG_CAPACITY, {16'($urandom), cap});
		reg_write(REG_AMOUNT, {16'($urandom), amt});
		reg_write(REG_PERIOD, per);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_cap = cap;
		cur_per = per;
	endtask

	function automatic logic [31:0] next_gap();
		bit [63:0] per;
		bit [63:0] span;
		per = (cur_per == 0) ? 64'd1 : 64'(cur_per);
		span = per * 4;
		if (span > 64'hFFFF_FFFF)
			span = 64'hFFFF_FFFF;
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return per[31:0];
			2: return per[31:0] + 32'd1;
			3: return $urandom_range(0, 7);
			default: return $urandom_range(0, span[31:0]);
		endcase
	endfunction

	function automatic logic [15:0] next_cost();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'($urandom);
			2: return cur_cap;
			3: return cur_cap + 16'd1;
			4, 5: return 16'($urandom_range(0, cur_cap / 4 + 1));
			default: return 16'($urandom_range(0, cur_cap));
		endcase
	endfunction

	task automatic random_request();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			slot_pool[$urandom_range(0, POOL_SIZE - 1)] = SLOT_BITS'($urandom);
		if (pick >= 85) begin
			send_word(SLOT_BITS'($urandom), $urandom, 16'($urandom));
		end else begin
			wall = wall + next_gap();
			send_word(slot_pool[$urandom_range(0, POOL_SIZE - 1)], wall, next_cost());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.user_slot = '0;
		req.current_time = '0;
		req.request_cost = '0;
		wall = $urandom;
		foreach (slot_pool[i])
			slot_pool[i] = SLOT_BITS'($urandom);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(10'd0, 32'd1000, 16'd0);
		send_word(10'd0, 32'd1000, 16'd300);
		send_word(10'd0, 32'd1600, 16'd0);
		send_word(10'd0, 32'd1601, 16'd1);
		send_word(10'd0, 32'd500, 16'd0);
		send_word(10'd0, 32'd7601, 16'hFFFF);
		send_word(10'h3FF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(10'h3FF, 32'hFFFF_FFFF, 16'd300);
		send_word(10'h3FF, 32'd0, 16'd0);
		send_word(10'h2AA, 32'hAAAA_AAAA, 16'h5555);
		send_word(10'h155, 32'h5555_5555, 16'hAAAA);
		send_word(10'h155, 32'h5555_5555, 16'd150);
		send_word(10'h155, 32'h5555_5555 + 32'd1801, 16'd1);
		settle();
		set_limits(16'd50, 16'd0, 32'd0);
		send_word(10'd0, 32'd8000, 16'd0);
		send_word(10'h155, 32'h6000_0000, 16'd0);
		send_word(10'h2AA, 32'd1, 16'd51);
		send_word(10'h3FF, 32'd100, 16'd0);
		settle();
		set_limits(16'd0, 16'd7, 32'd3);
		send_word(10'd5, 32'd0, 16'd0);
		send_word(10'd5, 32'd10, 16'd1);
		send_word(10'd0, 32'd9000, 16'd0);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_limits(16'hFFFF, 16'hFFFF, 32'd1);
				1: set_limits(16'd1, 16'd1, 32'hFFFF_FFFF);
				2: set_limits(16'd0, 16'd0, 32'd0);
				3: set_limits(RST_CAPACITY, RST_AMOUNT, RST_PERIOD);
				4: set_limits(16'hFFFF, 16'd1, 32'd1);
				7: set_limits(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 400)),
					$urandom);
				default: set_limits(16'($urandom_range(1, 3000)),
					16'($urandom_range(1, 400)), $urandom_range(1, 50));
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(0, 199) == 0)
					settle();
				random_request();
			end
			settle();
		end

		repeat (60) @(negedge clk);
		if (fails == 0 && owed == 0)
			$display("per_user_token_bucket_limiter regression: pass");
		else
			$display("per_user_token_bucket_limiter regression: fail");
		$finish;
	end

endmodule

[filelist.f]
sv/ptbl_pkg.sv
sv/ptbl_if.sv
sv/ptbl_div.sv
sv/ptbl_store.sv
sv/ptbl_cfg.sv
sv/ptbl_ctrl.sv
sv/per_user_token_bucket_limiter.sv
test/ptbl_admission_check.sv
test/tb.sv
